>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent and consequent in the same cycle
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// consequent in the cycle after the antecedent
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_SAME_CYCLE(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT_CYCLE(lbl, clk, rst, ante, cons)
`endif
`endif

>>> rtl/core/ogve_pkg.sv
// shared types, register codes and helpers for the voxel extruder
`timescale 1ns / 1ps
package ogve_pkg;

  localparam int unsigned MAX_LAYERS    = 64;
  localparam int unsigned MAX_GRID_SIDE = 4096;

  localparam int COORD_W    = $clog2(MAX_GRID_SIDE);
  localparam int LAYER_W    = $clog2(MAX_LAYERS);
  localparam int ROWS_W     = 13;
  localparam int CELL_W     = 20;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OCCUPIED_THRESHOLD,
    REG_UNKNOWN_IS_OBSTACLE,
    REG_GRID_ROWS,
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_CELL_SIZE,
    REG_LAYER_COUNT
  } cfg_reg_t;

  typedef struct packed {
    logic signed [7:0]       occupied_threshold;
    logic                    unknown_is_obstacle;
    logic [ROWS_W-1:0]       grid_rows;
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic [CELL_W-1:0]       cell_size;
    logic [6:0]              layer_count;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } cell_pos_t;

  // index of the top layer, count clamped to 1..MAX_LAYERS
  function automatic logic [LAYER_W-1:0] last_layer_index(input logic [6:0] count);
    logic [LAYER_W-1:0] idx;
    if (count == 7'd0) begin
      idx = '0;
    end else if (count > 7'(MAX_LAYERS)) begin
      idx = LAYER_W'(MAX_LAYERS - 1);
    end else begin
      idx = LAYER_W'(count - 7'd1);
    end
    return idx;
  endfunction

  // effective row count, clamped to 1..MAX_GRID_SIDE
  function automatic logic [ROWS_W-1:0] rows_clamped(input logic [ROWS_W-1:0] rows);
    logic [ROWS_W-1:0] r;
    if (rows == '0) begin
      r = ROWS_W'(1);
    end else if (rows > ROWS_W'(MAX_GRID_SIDE)) begin
      r = ROWS_W'(MAX_GRID_SIDE);
    end else begin
      r = rows;
    end
    return r;
  endfunction

endpackage

>>> rtl/core/ogve_cfg_regs.sv
// configuration register file
`timescale 1ns / 1ps
module ogve_cfg_regs import ogve_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.occupied_threshold  <= 8'sd50;
      cfg.unknown_is_obstacle <= 1'b0;
      cfg.grid_rows           <= ROWS_W'(MAX_GRID_SIDE);
      cfg.origin_x            <= '0;
      cfg.origin_y            <= '0;
      cfg.cell_size           <= CELL_W'(3277);
      cfg.layer_count         <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_OCCUPIED_THRESHOLD:  cfg.occupied_threshold  <= $signed(cfg_data[7:0]);
        REG_UNKNOWN_IS_OBSTACLE: cfg.unknown_is_obstacle <= cfg_data[0];
        REG_GRID_ROWS:           cfg.grid_rows           <= cfg_data[ROWS_W-1:0];
        REG_ORIGIN_X:            cfg.origin_x            <= $signed(cfg_data[POS_W-1:0]);
        REG_ORIGIN_Y:            cfg.origin_y            <= $signed(cfg_data[POS_W-1:0]);
        REG_CELL_SIZE:           cfg.cell_size           <= cfg_data[CELL_W-1:0];
        REG_LAYER_COUNT:         cfg.layer_count         <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/ogve_scan.sv
// scan position tracking, obstacle test and input register
`timescale 1ns / 1ps
module ogve_scan import ogve_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic signed [7:0] cell_value,
  input  logic              scan_start,
  input  logic              a_take,
  output logic              a_valid,
  output cell_pos_t         a_pos
);

  logic [COORD_W-1:0] column_index;
  logic [COORD_W-1:0] row_index;
  logic [COORD_W-1:0] col_cur;
  logic [COORD_W-1:0] row_cur;
  logic [ROWS_W-1:0]  rows_eff;
  logic               row_wrap;
  logic               obstacle;
  logic               accept;

  assign col_cur  = scan_start ? '0 : column_index;
  assign row_cur  = scan_start ? '0 : row_index;
  assign rows_eff = rows_clamped(cfg.grid_rows);
  // wrap also catches a row already past a lowered count
  assign row_wrap = ({1'b0, row_cur} + ROWS_W'(1)) >= rows_eff;
  assign obstacle = (cell_value >= cfg.occupied_threshold) ||
                    (cfg.unknown_is_obstacle && cell_value[7]);

  assign in_ready = !a_valid || a_take;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      row_index    <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (accept) begin
        if (row_wrap) begin
          row_index    <= '0;
          column_index <= col_cur + COORD_W'(1);
        end else begin
          row_index    <= row_cur + COORD_W'(1);
          column_index <= col_cur;
        end
      end
      if (accept && obstacle) begin
        a_valid <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && obstacle) begin
      a_pos.column <= col_cur;
      a_pos.row    <= row_cur;
    end
  end

endmodule

>>> rtl/core/ogve_layer.sv
// centre computation and per-layer result register
`timescale 1ns / 1ps
module ogve_layer import ogve_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  logic                    a_valid,
  input  cell_pos_t               a_pos,
  output logic                    a_take,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] center_x,
  output logic signed [POS_W-1:0] center_y,
  output logic signed [POS_W-1:0] center_z,
  output logic [COORD_W-1:0]      cell_column,
  output logic [COORD_W-1:0]      cell_row,
  output logic                    last_layer
);

  logic [POS_W-1:0]   col_off;
  logic [POS_W-1:0]   row_off;
  logic [POS_W-1:0]   half;
  logic [POS_W-1:0]   cx;
  logic [POS_W-1:0]   cy;
  logic [POS_W-1:0]   cz;
  logic [LAYER_W-1:0] layer;
  logic [LAYER_W-1:0] last_idx;
  logic               emit_done;
  logic               step;

  assign col_off  = POS_W'(a_pos.column) * POS_W'(cfg.cell_size);
  assign row_off  = POS_W'(a_pos.row) * POS_W'(cfg.cell_size);
  assign half     = POS_W'(cfg.cell_size >> 1);
  assign last_idx = last_layer_index(cfg.layer_count);

  assign last_layer = (layer == last_idx);
  assign emit_done  = out_valid && out_ready && last_layer;
  assign step       = out_valid && out_ready && !last_layer;
  assign a_take     = a_valid && (!out_valid || emit_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_take) begin
      out_valid <= 1'b1;
    end else if (emit_done) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_take) begin
      cx          <= $unsigned(cfg.origin_x) + col_off + half;
      cy          <= $unsigned(cfg.origin_y) + row_off + half;
      cz          <= half;
      layer       <= '0;
      cell_column <= a_pos.column;
      cell_row    <= a_pos.row;
    end else if (step) begin
      cz    <= cz + POS_W'(cfg.cell_size);
      layer <= layer + LAYER_W'(1);
    end
  end

  assign center_x = $signed(cx);
  assign center_y = $signed(cy);
  assign center_z = $signed(cz);

endmodule

>>> rtl/core/occupancy_grid_voxel_extruder.sv
// top level of the occupancy grid voxel extruder
// Occupancy cells come in column by column, rows inner, one request per cell;
// the row wraps at grid_rows and scan_start puts a cell back at column 0,
// row 0. Free cells produce nothing and are taken at one per cycle unless
// a cell waits in the input register. An obstacle cell produces layer_count
// (1 to 64) box centres in signed Q16.16, lowest layer first, last_layer on
// the top one, one per cycle from the result register while out_ready is
// high; it holds that register until its top centre leaves, so layer_count
// sets the sustained rate. A one-deep input register ahead of the result
// register lets the next cell be taken while a finished centre waits on
// out_ready; an obstacle cell passes the input, then the result register.
// The config port always answers ready and is meant to be written while idle.
`timescale 1ns / 1ps
module occupancy_grid_voxel_extruder import ogve_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  // cell requests
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [7:0]       cell_value,
  input  logic                    scan_start,
  // box centre results
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [POS_W-1:0] center_x,
  output logic signed [POS_W-1:0] center_y,
  output logic signed [POS_W-1:0] center_z,
  output logic [COORD_W-1:0]      cell_column,
  output logic [COORD_W-1:0]      cell_row,
  output logic                    last_layer
);

`include "assert_macros.svh"

  cfg_t      cfg;
  logic      a_valid;
  logic      a_take;
  cell_pos_t a_pos;

  // register file
  ogve_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // position counters, obstacle test, input register
  ogve_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cell_value (cell_value),
    .scan_start (scan_start),
    .a_take     (a_take),
    .a_valid    (a_valid),
    .a_pos      (a_pos)
  );

  // centre arithmetic and layer stepping in the result register
  ogve_layer u_layer (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .a_valid     (a_valid),
    .a_pos       (a_pos),
    .a_take      (a_take),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .center_x    (center_x),
    .center_y    (center_y),
    .center_z    (center_z),
    .cell_column (cell_column),
    .cell_row    (cell_row),
    .last_layer  (last_layer)
  );

  // a taken non-top layer is always followed by another layer
  `ASSERT_NEXT_CYCLE(a_more_layers, clk, rst, out_valid && out_ready && !last_layer, out_valid)
  // a queued cell moves into an empty result register at once
  `ASSERT_NEXT_CYCLE(a_queue_drains, clk, rst, a_valid && !out_valid, out_valid)
  // mid-cell with a cell queued, no further request is taken
  `ASSERT_SAME_CYCLE(a_hold_input, clk, rst, a_valid && out_valid && !last_layer, !in_ready)
  // top layer leaves with nothing queued: result register empties
  `ASSERT_NEXT_CYCLE(a_drain_empty, clk, rst,
                     out_valid && out_ready && last_layer && !a_valid, !out_valid)

endmodule
